/* src/ctc_timer_prescaler_calc_defines.svh */
// Assertion macros for the CTC timer prescaler calculator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CTC_TIMER_PRESCALER_CALC_DEFINES_SVH
`define CTC_TIMER_PRESCALER_CALC_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication on every rising clock edge outside reset
`define CTC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset
`define CTC_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CTC_ASSERT(lbl, clk, rstn, prop, msg)
`define CTC_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* src/ctc_pkg.sv */
// Shared types, constants and the prescaler trial table of the CTC prescaler calculator.
// No dependencies; imported by the divider, the selector and the top level.
`timescale 1ns / 1ps
package ctc_pkg;

	localparam int REQ_W      = 20;
	localparam int CLOCK_W    = 26;
	localparam int USED_W     = 15;
	localparam int DIVIDEND_W = CLOCK_W - 1;
	localparam int REM_W      = USED_W;
	localparam int STEP_W     = 5;
	localparam int TRIAL_W    = 4;
	localparam int SHIFT_W    = 4;
	localparam int INDEX_W    = 3;
	localparam int FACTOR_W   = 11;
	localparam int CMP_W_W    = 16;
	localparam int CMP_N_W    = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 72;

	localparam logic [CLOCK_W-1:0]    CLOCK_RESET    = CLOCK_W'(16000000);
	localparam logic [REQ_W-1:0]      MAX_REQUEST_HZ = REQ_W'(20000);
	localparam logic [STEP_W-1:0]     DIV_STEPS      = STEP_W'(DIVIDEND_W);
	localparam logic [TRIAL_W-1:0]    WIDE_COUNT     = TRIAL_W'(5);
	localparam logic [TRIAL_W-1:0]    TRIAL_COUNT    = TRIAL_W'(12);
	localparam logic [CMP_W_W-1:0]    WIDE_MAX       = 16'hFFFF;
	localparam logic [CMP_N_W-1:0]    NARROW_MAX     = 8'hFF;
	localparam logic [DIVIDEND_W-1:0] WIDE_LIMIT     = DIVIDEND_W'(17'h10000);
	localparam logic [DIVIDEND_W-1:0] NARROW_LIMIT   = DIVIDEND_W'(9'h100);

	// Result of both prescaler searches
	typedef struct packed {
		logic [CMP_W_W-1:0]  compare_wide;
		logic [INDEX_W-1:0]  prescale_wide_index;
		logic [FACTOR_W-1:0] divider_wide;
		logic                wide_no_fit;
		logic [CMP_N_W-1:0]  compare_narrow;
		logic [INDEX_W-1:0]  prescale_narrow_index;
		logic [FACTOR_W-1:0] divider_narrow;
		logic                narrow_no_fit;
	} ctc_result_t;

	// Log2 of the prescaler tried at each step: wide 1,8,64,256,1024,
	// then narrow 1,8,32,64,128,256,1024
	function automatic logic [SHIFT_W-1:0] trial_shift(input logic [TRIAL_W-1:0] t);
		logic [SHIFT_W-1:0] s;
		unique case (t)
			4'd0:    s = 4'd0;
			4'd1:    s = 4'd3;
			4'd2:    s = 4'd6;
			4'd3:    s = 4'd8;
			4'd4:    s = 4'd10;
			4'd5:    s = 4'd0;
			4'd6:    s = 4'd3;
			4'd7:    s = 4'd5;
			4'd8:    s = 4'd6;
			4'd9:    s = 4'd7;
			4'd10:   s = 4'd8;
			4'd11:   s = 4'd10;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

/* src/ctc_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ctc_pkg for widths and the step count.
`timescale 1ns / 1ps
module ctc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ctc_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [ctc_pkg::REM_W-1:0]        divisor,
	output logic                             done,
	output logic [ctc_pkg::DIVIDEND_W-1:0]   quotient
);
	import ctc_pkg::*;

	logic [REM_W-1:0]      rem_q;
	logic [REM_W-1:0]      dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        diff;
	logic                  ge;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	// Control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == DIV_STEPS - STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/ctc_sel.sv */
// Prescaler search: walks the trial table with one shift-and-compare unit.
// Depends on ctc_pkg for the trial table, limits and the result struct.
`timescale 1ns / 1ps
module ctc_sel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ctc_pkg::DIVIDEND_W-1:0] quotient,
	output logic                           done,
	output ctc_pkg::ctc_result_t           result
);
	import ctc_pkg::*;

	logic                  active_q;
	logic                  done_q;
	logic [TRIAL_W-1:0]    trial_q;
	ctc_result_t           res_q;
	logic [SHIFT_W-1:0]    shift;
	logic [DIVIDEND_W-1:0] q_sh;
	logic [DIVIDEND_W-1:0] q_dec;
	logic                  is_wide;
	logic                  fit;
	logic                  last_in_group;
	logic [INDEX_W-1:0]    local_idx;
	logic [FACTOR_W-1:0]   factor;

	// Candidate quotient for this prescaler and its fit test
	assign shift         = trial_shift(trial_q);
	assign q_sh          = quotient >> shift;
	assign q_dec         = q_sh - DIVIDEND_W'(1);
	assign is_wide       = trial_q < WIDE_COUNT;
	assign fit           = (q_sh != '0) && (q_sh <= (is_wide ? WIDE_LIMIT : NARROW_LIMIT));
	assign last_in_group = (trial_q == WIDE_COUNT - TRIAL_W'(1)) ||
	                       (trial_q == TRIAL_COUNT - TRIAL_W'(1));
	assign local_idx     = is_wide ? trial_q[INDEX_W-1:0] : INDEX_W'(trial_q - WIDE_COUNT);
	assign factor        = FACTOR_W'(1) << shift;

	// Sequencer: advance through the trials, skip the rest of a group on a fit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			trial_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				trial_q  <= '0;
			end else if (active_q) begin
				if (!is_wide && (fit || last_in_group)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else if (fit) begin
					trial_q <= WIDE_COUNT;
				end else begin
					trial_q <= trial_q + TRIAL_W'(1);
				end
			end
		end
	end

	// Record the chosen prescaler or the saturated answer of a group
	always_ff @(posedge clk) begin
		if (active_q && !start) begin
			if (is_wide) begin
				if (fit) begin
					res_q.compare_wide        <= q_dec[CMP_W_W-1:0];
					res_q.prescale_wide_index <= local_idx;
					res_q.divider_wide        <= factor;
					res_q.wide_no_fit         <= 1'b0;
				end else if (last_in_group) begin
					res_q.compare_wide        <= WIDE_MAX;
					res_q.prescale_wide_index <= '0;
					res_q.divider_wide        <= FACTOR_W'(1);
					res_q.wide_no_fit         <= 1'b1;
				end
			end else begin
				if (fit) begin
					res_q.compare_narrow        <= q_dec[CMP_N_W-1:0];
					res_q.prescale_narrow_index <= local_idx;
					res_q.divider_narrow        <= factor;
					res_q.narrow_no_fit         <= 1'b0;
				end else if (last_in_group) begin
					res_q.compare_narrow        <= NARROW_MAX;
					res_q.prescale_narrow_index <= '0;
					res_q.divider_narrow        <= FACTOR_W'(1);
					res_q.narrow_no_fit         <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* src/ctc_timer_prescaler_calc.sv */
// Top level of the CTC timer prescaler calculator: handshakes, clock register,
// sequencing and the output register. Depends on ctc_pkg, ctc_div, ctc_sel and the defines header.
`timescale 1ns / 1ps
`include "ctc_timer_prescaler_calc_defines.svh"
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data writes the timer clock in hertz (reset 16000000);
//   cfg_ready is always high. Write it only while no request is in flight.
//   s_axis carries one requested frequency per beat; m_axis returns one result
//   beat per request with the clamped frequency and, for the 16-bit and the
//   8-bit timer, the compare value, prescaler index, division factor and a
//   no-fit flag.
// Timing:
//   A request is accepted, then divided in the bit-serial divider (clock/2
//   divided by the frequency, one quotient bit per cycle); the divider's done
//   pulse starts the shared shift-and-compare search, whose result is loaded
//   into the output register. One request is in work at a time: s_axis_tready
//   is high only while the sequencer is idle, so a new request is accepted
//   only once the last result has been loaded into the output register.
//   The output register lets a new request be accepted while a result waits;
//   if that next result finishes before the old one is taken, it holds in the
//   search unit until the receiver raises m_axis_tready.
// Reset: arst_n clears the sequencer and the output valid and restores the clock.
module ctc_timer_prescaler_calc (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctc_pkg::CLOCK_W-1:0]      cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// s_axis_tdata, from bit 0: requested_hz[19:0], zero fill
	input  logic [ctc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// m_axis_tdata, from bit 0: used_hz[14:0], compare_wide[15:0],
	// prescale_wide_index[2:0], divider_wide[10:0], wide_no_fit,
	// compare_narrow[7:0], prescale_narrow_index[2:0], divider_narrow[10:0],
	// narrow_no_fit, zero fill
	output logic [ctc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import ctc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CLOCK_W-1:0]     clock_q;
	logic [USED_W-1:0]      used_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [REQ_W-1:0]       req;
	logic [USED_W-1:0]      used_hz;
	logic                   in_accept;
	logic                   slot_free;
	logic                   load_out;
	logic                   div_done;
	logic [DIVIDEND_W-1:0]  quotient;
	logic                   sel_done;
	ctc_result_t            res;

	// Clamp the request into the usable range
	assign req       = s_axis_tdata[REQ_W-1:0];
	assign used_hz   = ((req == '0) || (req > MAX_REQUEST_HZ)) ?
	                   MAX_REQUEST_HZ[USED_W-1:0] : req[USED_W-1:0];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Hold the timer clock register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg_valid) begin
			clock_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			used_q <= used_hz;
		end
	end

	ctc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.dividend (clock_q[CLOCK_W-1:1]),
		.divisor  (used_hz),
		.done     (div_done),
		.quotient (quotient)
	);

	ctc_sel u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_done),
		.quotient (quotient),
		.done     (sel_done),
		.result   (res)
	);

	// Sequence one request through divide, search and output load
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign load_out      = ((state_q == ST_SEL) && sel_done && slot_free) ||
	                       ((state_q == ST_HOLD) && slot_free);
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (sel_done) state_q <= slot_free ? ST_IDLE : ST_HOLD;
				end
				ST_HOLD: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load a finished result, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {3'b000,
			               res.narrow_no_fit, res.divider_narrow,
			               res.prescale_narrow_index, res.compare_narrow,
			               res.wide_no_fit, res.divider_wide,
			               res.prescale_wide_index, res.compare_wide,
			               used_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`CTC_ASSERT(a_div_done_in_div, clk, arst_n, div_done |-> (state_q == ST_DIV), "divider finished outside the divide state")
	`CTC_ASSERT(a_sel_done_in_sel, clk, arst_n, sel_done |-> (state_q == ST_SEL), "search finished outside the search state")
	`CTC_NEVER(a_wide_no_fit_sat, clk, arst_n, load_out && res.wide_no_fit && ((res.compare_wide != WIDE_MAX) || (res.divider_wide != FACTOR_W'(1))), "wide no-fit result not saturated")
	`CTC_NEVER(a_narrow_no_fit_sat, clk, arst_n, load_out && res.narrow_no_fit && ((res.compare_narrow != NARROW_MAX) || (res.divider_narrow != FACTOR_W'(1))), "narrow no-fit result not saturated")

endmodule

/* tb/tb_ctc_timer_prescaler_calc.sv */
// Self-checking bench for the CTC timer prescaler calculator: a directed table, then
// random requests over several timer clock settings, checked against a local predictor.
// Depends on ctc_pkg and the ctc_timer_prescaler_calc top level.
`timescale 1ns / 1ps
module tb_ctc_timer_prescaler_calc;
	import ctc_pkg::*;

	// Prescalers in trial order: the 16-bit timer first, then the 8-bit timer
	localparam int WIDE_TRIALS = 5;
	localparam int ALL_TRIALS  = 12;
	localparam int unsigned PRESCALERS [ALL_TRIALS] = '{1, 8, 64, 256, 1024,
		1, 8, 32, 64, 128, 256, 1024};
	localparam int PHASES          = 14;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int MAX_LOGGED      = 60;

	// One result beat, field by field
	typedef struct packed {
		logic [USED_W-1:0]   used_hz;
		logic [CMP_W_W-1:0]  compare_wide;
		logic [INDEX_W-1:0]  wide_index;
		logic [FACTOR_W-1:0] divider_wide;
		logic                wide_no_fit;
		logic [CMP_N_W-1:0]  compare_narrow;
		logic [INDEX_W-1:0]  narrow_index;
		logic [FACTOR_W-1:0] divider_narrow;
		logic                narrow_no_fit;
	} prescale_beat_t;

	typedef struct {
		logic                set_clock;
		logic [CLOCK_W-1:0]  clock_hz;
		logic [REQ_W-1:0]    request;
		logic                typed;
		prescale_beat_t      result;
	} directed_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CLOCK_W-1:0]     cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	prescale_beat_t     pending_prescale_q[$];
	directed_row_t      directed_rows[$];
	logic [CLOCK_W-1:0] clock_setting = CLOCK_RESET;
	logic               steady_flow = 1'b0;
	int                 ready_hold = 0;
	int                 mismatch_count = 0;
	int                 sent_count = 0;
	int                 checked_count = 0;
	int                 clock_writes = 0;

	always #4 clk = ~clk;

	ctc_timer_prescaler_calc u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Compute the expected beat: clamp the request, then take the first prescaler
	// whose compare value fits each timer, else saturate and flag no fit
	function automatic prescale_beat_t calc_prescale_setting(input logic [CLOCK_W-1:0] clock_hz,
			input logic [REQ_W-1:0] req);
		prescale_beat_t    r;
		longint unsigned   f;
		longint unsigned   d;
		longint unsigned   q;
		logic              wide_found;
		logic              narrow_found;
		f = longint'(req);
		if (f == 0 || f > longint'(MAX_REQUEST_HZ)) begin
			f = longint'(MAX_REQUEST_HZ);
		end
		r.used_hz        = f[USED_W-1:0];
		r.compare_wide   = WIDE_MAX;
		r.wide_index     = '0;
		r.divider_wide   = FACTOR_W'(1);
		r.wide_no_fit    = 1'b1;
		r.compare_narrow = NARROW_MAX;
		r.narrow_index   = '0;
		r.divider_narrow = FACTOR_W'(1);
		r.narrow_no_fit  = 1'b1;
		wide_found   = 1'b0;
		narrow_found = 1'b0;
		for (int t = 0; t < ALL_TRIALS; t++) begin
			d = longint'(PRESCALERS[t]);
			q = longint'(clock_hz) / (64'd2 * d * f);
			if (t < WIDE_TRIALS) begin
				if (!wide_found && q >= 1 && q - 1 <= longint'(WIDE_MAX)) begin
					r.compare_wide = CMP_W_W'(q - 1);
					r.wide_index   = INDEX_W'(t);
					r.divider_wide = FACTOR_W'(d);
					r.wide_no_fit  = 1'b0;
					wide_found     = 1'b1;
				end
			end else if (!narrow_found && q >= 1 && q - 1 <= longint'(NARROW_MAX)) begin
				r.compare_narrow = CMP_N_W'(q - 1);
				r.narrow_index   = INDEX_W'(t - WIDE_TRIALS);
				r.divider_narrow = FACTOR_W'(d);
				r.narrow_no_fit  = 1'b0;
				narrow_found     = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic prescale_beat_t make_beat(input int used, input int cw, input int iw,
			input int dw, input int nw, input int cn, input int in8, input int dn, input int nn);
		prescale_beat_t r;
		r.used_hz        = USED_W'(used);
		r.compare_wide   = CMP_W_W'(cw);
		r.wide_index     = INDEX_W'(iw);
		r.divider_wide   = FACTOR_W'(dw);
		r.wide_no_fit    = 1'(nw);
		r.compare_narrow = CMP_N_W'(cn);
		r.narrow_index   = INDEX_W'(in8);
		r.divider_narrow = FACTOR_W'(dn);
		r.narrow_no_fit  = 1'(nn);
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (steady_flow) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Bias requests toward the usable range, its edges and out-of-range values
	function automatic logic [REQ_W-1:0] random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return REQ_W'($urandom_range(1, 20000));
		if (r < 60) return REQ_W'($urandom_range(1, 400));
		if (r < 70) begin
			case ($urandom_range(0, 4))
				0:       return '0;
				1:       return REQ_W'(1);
				2:       return MAX_REQUEST_HZ;
				3:       return MAX_REQUEST_HZ + 1'b1;
				default: return MAX_REQUEST_HZ - 1'b1;
			endcase
		end
		return REQ_W'($urandom);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_LOGGED) begin
			$display("mismatch at beat %0d, %s: got %0d, want %0d", checked_count, field,
				got, want);
		end
	endtask

	task automatic add_row(input logic set_clock, input logic [CLOCK_W-1:0] clock_hz,
			input logic [REQ_W-1:0] request, input logic typed, input prescale_beat_t result);
		directed_row_t row;
		row.set_clock = set_clock;
		row.clock_hz  = clock_hz;
		row.request   = request;
		row.typed     = typed;
		row.result    = result;
		directed_rows.push_back(row);
	endtask

	// Hold off new requests until every result beat has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_prescale_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_clock(input logic [CLOCK_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid     <= 1'b0;
		clock_setting  = value;
		clock_writes++;
	endtask

	// Offer one request beat and queue its expected result once accepted
	task automatic send_request(input logic [REQ_W-1:0] hz, input prescale_beat_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(hz);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_prescale_q.push_back(want);
		sent_count++;
	endtask

	// Unpack a result beat and compare it with the oldest expectation
	task automatic check_prescale_beat();
		prescale_beat_t got;
		prescale_beat_t want;
		got.used_hz        = m_axis_tdata[14:0];
		got.compare_wide   = m_axis_tdata[30:15];
		got.wide_index     = m_axis_tdata[33:31];
		got.divider_wide   = m_axis_tdata[44:34];
		got.wide_no_fit    = m_axis_tdata[45];
		got.compare_narrow = m_axis_tdata[53:46];
		got.narrow_index   = m_axis_tdata[56:54];
		got.divider_narrow = m_axis_tdata[67:57];
		got.narrow_no_fit  = m_axis_tdata[68];
		if (pending_prescale_q.size() == 0) begin
			report_mismatch("beat with no request pending", m_axis_tdata[63:0], 64'd0);
		end else begin
			want = pending_prescale_q.pop_front();
			if (got.used_hz !== want.used_hz)
				report_mismatch("used_hz", got.used_hz, want.used_hz);
			if (got.compare_wide !== want.compare_wide)
				report_mismatch("compare_wide", got.compare_wide, want.compare_wide);
			if (got.wide_index !== want.wide_index)
				report_mismatch("prescale_wide_index", got.wide_index, want.wide_index);
			if (got.divider_wide !== want.divider_wide)
				report_mismatch("divider_wide", got.divider_wide, want.divider_wide);
			if (got.wide_no_fit !== want.wide_no_fit)
				report_mismatch("wide_no_fit", got.wide_no_fit, want.wide_no_fit);
			if (got.compare_narrow !== want.compare_narrow)
				report_mismatch("compare_narrow", got.compare_narrow, want.compare_narrow);
			if (got.narrow_index !== want.narrow_index)
				report_mismatch("prescale_narrow_index", got.narrow_index, want.narrow_index);
			if (got.divider_narrow !== want.divider_narrow)
				report_mismatch("divider_narrow", got.divider_narrow, want.divider_narrow);
			if (got.narrow_no_fit !== want.narrow_no_fit)
				report_mismatch("narrow_no_fit", got.narrow_no_fit, want.narrow_no_fit);
		end
		checked_count++;
	endtask

	// Take result beats and stall the receiver at random
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			check_prescale_beat();
		end
		if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= ready_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold    <= pick_gap();
		end
	end

	// Stimulus: directed table, then random phases over several clock settings
	initial begin
		prescale_beat_t     at_reset;
		prescale_beat_t     want;
		logic [CLOCK_W-1:0] clk_v;
		logic [REQ_W-1:0]   hz;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;

		// 16 MHz, 20 kHz: 399 with no prescaler, 49 with the 8-bit timer at /8
		at_reset = make_beat(20000, 399, 0, 1, 0, 49, 1, 8, 0);
		add_row(1'b0, '0, REQ_W'(20000), 1'b1, at_reset);
		// out-of-range requests fall back to the maximum frequency
		add_row(1'b0, '0, '0, 1'b1, at_reset);
		add_row(1'b0, '0, REQ_W'(20001), 1'b1, at_reset);
		add_row(1'b0, '0, REQ_W'(20'hFFFFF), 1'b1, at_reset);
		add_row(1'b0, '0, REQ_W'(1), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(19999), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(123), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(20'h80000), 1'b0, at_reset);
		// zero clock: every quotient is zero, both timers saturate
		add_row(1'b1, '0, REQ_W'(1), 1'b1, make_beat(1, 65535, 0, 1, 1, 255, 0, 1, 1));
		add_row(1'b0, '0, REQ_W'(20000), 1'b1,
			make_beat(20000, 65535, 0, 1, 1, 255, 0, 1, 1));
		// clock below twice the frequency: quotient of zero at the first trial
		add_row(1'b1, CLOCK_W'(1), REQ_W'(500), 1'b1,
			make_beat(500, 65535, 0, 1, 1, 255, 0, 1, 1));
		add_row(1'b1, CLOCK_W'(39999), REQ_W'(20000), 1'b1,
			make_beat(20000, 65535, 0, 1, 1, 255, 0, 1, 1));
		add_row(1'b0, '0, REQ_W'(1), 1'b0, at_reset);
		// largest register value
		add_row(1'b1, {CLOCK_W{1'b1}}, REQ_W'(1), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(20000), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(7), 1'b0, at_reset);
		// ends of the usual clock range
		add_row(1'b1, CLOCK_W'(1000000), REQ_W'(1), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(20000), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(333), 1'b0, at_reset);
		add_row(1'b1, CLOCK_W'(64000000), REQ_W'(1), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(20000), 1'b0, at_reset);
		add_row(1'b0, '0, REQ_W'(4000), 1'b0, at_reset);
		add_row(1'b1, CLOCK_RESET, REQ_W'(2), 1'b0, at_reset);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_clock) begin
				write_clock(directed_rows[i].clock_hz);
			end
			want = directed_rows[i].typed ? directed_rows[i].result
				: calc_prescale_setting(clock_setting, directed_rows[i].request);
			send_request(directed_rows[i].request, want);
		end

		// Random phases, one clock setting each
		for (int p = 0; p < PHASES; p++) begin
			case (p % 8)
				0:       clk_v = CLOCK_RESET;
				1:       clk_v = CLOCK_W'(1000000);
				2:       clk_v = CLOCK_W'(64000000);
				3:       clk_v = {CLOCK_W{1'b1}};
				4:       clk_v = CLOCK_W'($urandom_range(0, 200000));
				7:       clk_v = CLOCK_W'($urandom);
				default: clk_v = CLOCK_W'($urandom_range(1000000, 64000000));
			endcase
			write_clock(clk_v);
			steady_flow = (p % 5 == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				hz = random_request();
				send_request(hz, calc_prescale_setting(clock_setting, hz));
			end
		end

		// Let the last results drain, then a short tail
		drain_results();
		repeat (50) @(posedge clk);
		$display("covered %0d requests over %0d clock register writes, %0d result beats taken",
			sent_count, clock_writes, checked_count);
		$display("mismatches found: %0d", mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/ctc_pkg.sv
src/ctc_div.sv
src/ctc_sel.sv
src/ctc_timer_prescaler_calc.sv
tb/tb_ctc_timer_prescaler_calc.sv
